@@ design/orrb_pkg.sv @@
package orrb_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

endpackage

@@ design/overwriting_receive_ring_buffer.sv @@
// Overwriting receive ring buffer.
//
// Bytes from a serial receiver go into a circular store. Software takes them
// out oldest first. Both directions share one command channel: a word is taken
// at a rising edge with start high and busy low. busy stays low, so one word
// can be taken in every cycle.
//   op = push : store rx_byte at the write pointer and advance it. If the write
//               pointer then meets the read pointer, drop the oldest byte by
//               advancing the read pointer too. The buffer holds at most
//               DEPTH-1 bytes. A push gives no result.
//   op = pop  : give the oldest byte and advance the read pointer. On an empty
//               buffer, give read_byte zero with was_empty high; no pointer moves.
// Latency: a pop result shows on read_byte/was_empty with done high for exactly
// one cycle, the cycle right after the pop is taken. The store is one memory
// with one write port and one registered read port, so throughput is one word
// per cycle. The receiver cannot hold results off; none is ever pending past
// the cycle in which done shows it.
// Reset clears both pointers (buffer empty) and done; store contents stay
// undefined until written; an unwritten entry read by an empty pop shows as zero.
module overwriting_receive_ring_buffer
    import orrb_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  byte_t       rx_byte,
    output logic        done,
    output byte_t       read_byte,
    output logic        was_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    // Pointer and result registers
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic             done_reg;
    logic             empty_reg;
    byte_t            rd_data_reg;

    byte_t            byte_store_reg [DEPTH];

    logic             take;
    logic             push_take;
    logic             pop_take;
    logic             is_empty;
    logic [PTR_W-1:0] wr_ptr_inc;
    logic [PTR_W-1:0] rd_ptr_inc;

    // Never stalls: every item completes in a single pass.
    assign busy      = 1'b0;
    assign take      = start && !busy;
    assign push_take = take && (op == OP_PUSH);
    assign pop_take  = take && (op == OP_POP);
    assign is_empty  = (wr_ptr_reg == rd_ptr_reg);

    // Advance with wrap at DEPTH
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push_take)
        begin
            wr_ptr_next = wr_ptr_inc;
            // Full: drop the oldest byte
            if (wr_ptr_inc == rd_ptr_reg)
            begin
                rd_ptr_next = rd_ptr_inc;
            end
        end
        else if (pop_take && !is_empty)
        begin
            rd_ptr_next = rd_ptr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            done_reg   <= 1'b0;
            empty_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            done_reg   <= pop_take;
            if (pop_take)
            begin
                empty_reg <= is_empty;
            end
        end
    end

    // Store: one write port, one registered read port. A pop right after a
    // push sees that byte, since the write landed at the earlier edge.
    always_ff @(posedge clk)
    begin
        if (push_take)
        begin
            byte_store_reg[wr_ptr_reg] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_take)
        begin
            rd_data_reg <= byte_store_reg[rd_ptr_reg];
        end
    end

    assign done      = done_reg;
    assign was_empty = empty_reg;
    assign read_byte = empty_reg ? '0 : rd_data_reg;

endmodule

@@ design/orrb_checker.sv @@
module orrb_checker
    import orrb_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  start,
    input logic  busy,
    input logic  op,
    input byte_t rx_byte,
    input logic  done,
    input byte_t read_byte,
    input logic  was_empty
);

    // A result only ever follows an accepted pop
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (op == OP_POP)))
        else $error("result without a preceding pop");

    // Every accepted pop gives a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_POP)) |=> done)
        else $error("pop without result");

    // A push gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_PUSH)) |=> !done)
        else $error("result after a push");

    // Empty pop returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && was_empty) |-> (read_byte == '0))
        else $error("empty pop returned a nonzero byte");

endmodule

bind overwriting_receive_ring_buffer orrb_checker u_orrb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .op        (op),
    .rx_byte   (rx_byte),
    .done      (done),
    .read_byte (read_byte),
    .was_empty (was_empty)
);

@@ dv/tb_overwriting_receive_ring_buffer.sv @@
`timescale 1ns / 1ps

module tb_overwriting_receive_ring_buffer;

    import orrb_pkg::*;

    // Match the block's default size.
    localparam int RING_DEPTH = 1024;

    // Each pop gives one result word; pushes give nothing.
    typedef struct packed
    {
        byte_t read_byte;
        logic  was_empty;
    } pop_result_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  start = 1'b0;
    logic  op = OP_PUSH;
    byte_t rx_byte = '0;
    logic  busy;
    logic  done;
    byte_t read_byte;
    logic  was_empty;

    // Shadow copy of the ring: contents and both pointers.
    byte_t ring_mem [RING_DEPTH];
    int    wr_ptr = 0;
    int    rd_ptr = 0;

    // Results owed by pops that the block has taken, oldest first.
    pop_result_t pop_results_due [$];

    int fail_count = 0;

    // Sender gaps on or off; cleared for the closing back-to-back part.
    bit idle_enable = 1'b1;

    overwriting_receive_ring_buffer #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .op       (op),
        .rx_byte  (rx_byte),
        .done     (done),
        .read_byte(read_byte),
        .was_empty(was_empty)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Hard stop in case the block hangs or never answers.
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Apply one accepted word to the shadow ring and queue the result it owes.
    task automatic ring_update(input op_t cmd, input byte_t data);
        pop_result_t owed;
        if (cmd == OP_PUSH)
        begin
            // Store, advance; on meeting the read pointer drop the oldest byte.
            ring_mem[wr_ptr] = data;
            wr_ptr = (wr_ptr + 1) % RING_DEPTH;
            if (wr_ptr == rd_ptr)
                rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        end
        else if (wr_ptr == rd_ptr)
        begin
            // Empty: flag it, return zero, hold both pointers.
            owed.read_byte = '0;
            owed.was_empty = 1'b1;
            pop_results_due.push_back(owed);
        end
        else
        begin
            owed.read_byte = ring_mem[rd_ptr];
            owed.was_empty = 1'b0;
            pop_results_due.push_back(owed);
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
        end
    endtask

    // Pick an idle burst ahead of the next word: mostly none, else a random nonzero length.
    function automatic int pick_gap();
        if (!idle_enable)
            return 0;
        if ($urandom_range(3) != 0)
            return 0;
        return $urandom_range(19, 1);
    endfunction

    // Drive one word and hold it until the block takes it.
    // Called at a rising edge; returns at the edge that accepted the word.
    task automatic send_word(input op_t cmd, input byte_t data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        op      <= cmd;
        rx_byte <= data;
        // Inputs and busy are read at the edge, before the block's own updates land.
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ring_update(cmd, data);
    endtask

    // Check every strobed result against the oldest owed one.
    always @(posedge clk)
    begin : check_results
        pop_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pop_results_due.size() == 0)
            begin
                $error("result word with none owed: read_byte %0h was_empty %0b",
                       read_byte, was_empty);
                fail_count++;
            end
            else
            begin
                want = pop_results_due.pop_front();
                if (read_byte !== want.read_byte)
                begin
                    $error("read_byte expected %0h actual %0h", want.read_byte, read_byte);
                    fail_count++;
                end
                if (was_empty !== want.was_empty)
                begin
                    $error("was_empty expected %0b actual %0b", want.was_empty, was_empty);
                    fail_count++;
                end
            end
        end
        else if (rst_n && done !== 1'b0)
        begin
            $error("done expected 0 or 1 actual %b", done);
            fail_count++;
        end
    end

    // Hand-picked words: empty pop, byte extremes, pop ignoring rx_byte,
    // refill after empty, interleaved push and pop.
    task automatic test_directed();
        send_word(OP_POP,  8'h00);
        send_word(OP_POP,  8'hFF);
        send_word(OP_PUSH, 8'h00);
        send_word(OP_PUSH, 8'hFF);
        send_word(OP_PUSH, 8'h80);
        send_word(OP_PUSH, 8'h01);
        send_word(OP_POP,  8'hFF);
        send_word(OP_POP,  8'h00);
        send_word(OP_POP,  8'hA5);
        send_word(OP_POP,  8'h5A);
        send_word(OP_POP,  8'hFF);
        send_word(OP_PUSH, 8'h7F);
        send_word(OP_POP,  8'h00);
        send_word(OP_POP,  8'h00);
        send_word(OP_PUSH, 8'hAA);
        send_word(OP_PUSH, 8'h55);
        send_word(OP_POP,  8'h00);
        send_word(OP_PUSH, 8'h3C);
        send_word(OP_POP,  8'hFF);
        send_word(OP_POP,  8'h00);
        send_word(OP_POP,  8'h00);
    endtask

    // Random traffic in segments with different push/pop balance, so the ring
    // both runs dry and builds up; idling is chosen at random per segment.
    task automatic test_random_mix();
        int push_pct;
        op_t cmd;
        for (int seg = 0; seg < 6; seg++)
        begin
            case ($urandom_range(2))
                0: push_pct = 25;
                1: push_pct = 50;
                default: push_pct = 75;
            endcase
            idle_enable = ($urandom_range(2) != 0);
            for (int i = 0; i < 40; i++)
            begin
                cmd = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
                send_word(cmd, byte_t'($urandom_range(255)));
            end
        end
        idle_enable = 1'b1;
    endtask

    // Build the ring up, churn with pushes and pops mixed, then pop part of it
    // back out and finish with a short random tail. Runs back to back.
    task automatic test_fill_drain();
        idle_enable = 1'b0;
        for (int i = 0; i < 60; i++)
            send_word(OP_PUSH, byte_t'($urandom_range(255)));
        for (int i = 0; i < 10; i++)
        begin
            send_word(OP_PUSH, byte_t'($urandom_range(255)));
            send_word(OP_PUSH, byte_t'($urandom_range(255)));
            send_word(OP_POP, byte_t'($urandom_range(255)));
        end
        for (int i = 0; i < 40; i++)
            send_word(OP_POP, byte_t'($urandom_range(255)));
        // Short random tail straight after the drain.
        for (int i = 0; i < 20; i++)
            send_word(($urandom_range(1) != 0) ? OP_PUSH : OP_POP,
                      byte_t'($urandom_range(255)));
    endtask

    initial
    begin
        // Hold reset, then release it on an edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix();
        test_fill_drain();

        start <= 1'b0;
        // Drain owed results, then keep watching for stray strobes.
        while (pop_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
design/orrb_pkg.sv
design/overwriting_receive_ring_buffer.sv
design/orrb_checker.sv
dv/tb_overwriting_receive_ring_buffer.sv
